// ===== rtl/clp_pkg.sv =====
// Package for the character grid line plotter: field widths, request codes,
// controller states and the command/status structs. Depends on nothing.
`default_nettype none

package clp_pkg;

    // Default screen size
    localparam int DEF_SCREEN_COLS = 80;
    localparam int DEF_SCREEN_ROWS = 23;

    // Grid to screen scaling
    localparam int COL_SCALE = 3;
    localparam int ROW_SCALE = 2;

    // Field widths
    localparam int REQ_W = 2;
    localparam int GX_W  = 5;
    localparam int GY_W  = 4;
    localparam int COL_W = 7;
    localparam int ROW_W = 5;
    localparam int DY_W  = 6;
    localparam int ERR_W = 8;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_DRAW  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_LINE,
        ST_VERT,
        ST_READ,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic load;
        logic clear_step;
        logic start_mark;
        logic line_step;
        logic vert_step;
        logic load_result;
    } cmd_t;

    typedef struct packed {
        logic vertical;
        logic line_done;
        logic vert_last;
        logic clear_last;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/clp_req_if.sv =====
// Request channel of the line plotter: valid/ready plus request payload.
// Depends on clp_pkg.
`default_nettype none

interface clp_req_if import clp_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [GX_W-1:0]  x_a;
    logic [GY_W-1:0]  y_a;
    logic [GX_W-1:0]  x_b;
    logic [GY_W-1:0]  y_b;
    logic [COL_W-1:0] read_col;
    logic [ROW_W-1:0] read_row;

    modport source (
        output valid, req_type, x_a, y_a, x_b, y_b, read_col, read_row,
        input  ready
    );

    modport sink (
        input  valid, req_type, x_a, y_a, x_b, y_b, read_col, read_row,
        output ready
    );

endinterface

`default_nettype wire

// ===== rtl/clp_rsp_if.sv =====
// Response channel of the line plotter: valid/ready plus the read result.
// Depends on clp_pkg.
`default_nettype none

interface clp_rsp_if import clp_pkg::*; ();

    logic valid;
    logic ready;
    logic cell_marked;

    modport source (
        output valid, cell_marked,
        input  ready
    );

    modport sink (
        input  valid, cell_marked,
        output ready
    );

endinterface

`default_nettype wire

// ===== rtl/clp_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module clp_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/clp_dp.sv =====
// Datapath of the line plotter: endpoint setup, error-accumulator stepper,
// clear sweep counter, bitmap RAM and result register. Depends on clp_pkg, clp_ram.
`default_nettype none

module clp_dp import clp_pkg::*; #(
    parameter int SCREEN_COLS = DEF_SCREEN_COLS,
    parameter int SCREEN_ROWS = DEF_SCREEN_ROWS
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cmd_t             cmd,
    output sts_t                  sts,
    input  wire logic [REQ_W-1:0] req_type,
    input  wire logic [GX_W-1:0]  x_a,
    input  wire logic [GY_W-1:0]  y_a,
    input  wire logic [GX_W-1:0]  x_b,
    input  wire logic [GY_W-1:0]  y_b,
    input  wire logic [COL_W-1:0] read_col,
    input  wire logic [ROW_W-1:0] read_row,
    output logic                  cell_marked
);

    localparam int CW    = $clog2(SCREEN_COLS);
    localparam int RW    = $clog2(SCREEN_ROWS);
    localparam int DEPTH = SCREEN_ROWS << CW;
    localparam int AW    = $clog2(DEPTH);

    function automatic logic on_screen(logic [COL_W-1:0] c, logic [ROW_W-1:0] r);
        on_screen = (int'(c) < SCREEN_COLS) && (int'(r) < SCREEN_ROWS);
    endfunction

    function automatic logic [AW-1:0] cell_addr(logic [COL_W-1:0] c,
                                                logic [ROW_W-1:0] r);
        logic [CW-1:0] ca;
        logic [RW-1:0] ra;
        ca = CW'(c);
        ra = RW'(r);
        cell_addr = AW'({ra, ca});
    endfunction

    logic [COL_W-1:0]        cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]        cur_row_reg, cur_row_next;
    logic [COL_W-1:0]        end_col_reg, end_col_next;
    logic [ROW_W-1:0]        end_row_reg, end_row_next;
    logic [COL_W-1:0]        dx_reg, dx_next;
    logic signed [DY_W-1:0]  dy_reg, dy_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic [AW-1:0]           clr_cnt_reg, clr_cnt_next;
    logic                    cell_marked_reg, cell_marked_next;

    // endpoint setup
    logic [COL_W-1:0] xa3, xb3, x1, x2;
    logic [ROW_W-1:0] ya2, yb2, y1, y2, ylo, yhi;
    logic             swap;

    // stepper
    logic signed [ERR_W-1:0] dx_s, dy_s;
    logic                    err_up, err_dn;
    logic [COL_W-1:0]        col_inc;
    logic [COL_W-1:0]        mark_col;
    logic                    mark_act;

    // RAM ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic          ram_rdata;

    assign xa3  = COL_W'(x_a) * COL_W'(COL_SCALE);
    assign xb3  = COL_W'(x_b) * COL_W'(COL_SCALE);
    assign ya2  = ROW_W'(y_a) * ROW_W'(ROW_SCALE);
    assign yb2  = ROW_W'(y_b) * ROW_W'(ROW_SCALE);
    assign swap = !(x_a < x_b);
    assign x1   = swap ? xb3 : xa3;
    assign y1   = swap ? yb2 : ya2;
    assign x2   = swap ? xa3 : xb3;
    assign y2   = swap ? ya2 : yb2;
    assign ylo  = (ya2 < yb2) ? ya2 : yb2;
    assign yhi  = (ya2 < yb2) ? yb2 : ya2;

    assign dx_s    = signed'({1'b0, dx_reg});
    assign dy_s    = ERR_W'(dy_reg);
    assign err_up  = err_reg >= dx_s;
    assign err_dn  = err_reg < 0;
    assign col_inc = cur_col_reg + COL_W'(1);

    // Row runs mark the current column; a settled error marks the next column.
    assign mark_col = (cmd.line_step && !err_up && !err_dn) ? col_inc : cur_col_reg;
    assign mark_act = cmd.start_mark || cmd.line_step || cmd.vert_step;

    always_comb
    begin
        cur_col_next     = cur_col_reg;
        cur_row_next     = cur_row_reg;
        end_col_next     = end_col_reg;
        end_row_next     = end_row_reg;
        dx_next          = dx_reg;
        dy_next          = dy_reg;
        err_next         = err_reg;
        clr_cnt_next     = clr_cnt_reg;
        cell_marked_next = cell_marked_reg;

        if (cmd.load)
        begin
            case (req_type)
                REQ_DRAW:
                begin
                    cur_col_next = x1;
                    cur_row_next = (x_a == x_b) ? ylo : y1;
                    end_col_next = x2;
                    end_row_next = yhi;
                    dx_next      = x2 - x1;
                    dy_next      = signed'(DY_W'(y2)) - signed'(DY_W'(y1));
                    err_next     = ERR_W'(signed'(DY_W'(y2)) - signed'(DY_W'(y1)));
                end
                REQ_READ:
                begin
                    cur_col_next = read_col;
                    cur_row_next = read_row;
                end
                REQ_CLEAR:
                begin
                    clr_cnt_next = '0;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.line_step)
        begin
            if (err_up)
            begin
                cur_row_next = cur_row_reg + ROW_W'(1);
                err_next     = err_reg - dx_s;
            end
            else if (err_dn)
            begin
                cur_row_next = cur_row_reg - ROW_W'(1);
                err_next     = err_reg + dx_s;
            end
            else
            begin
                cur_col_next = col_inc;
                err_next     = err_reg + dy_s;
            end
        end

        if (cmd.vert_step)
        begin
            cur_row_next = cur_row_reg + ROW_W'(1);
        end

        if (cmd.clear_step)
        begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
        end

        if (cmd.load_result)
        begin
            cell_marked_next = on_screen(cur_col_reg, cur_row_reg) && ram_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_col_reg     <= cur_col_next;
        cur_row_reg     <= cur_row_next;
        end_col_reg     <= end_col_next;
        end_row_reg     <= end_row_next;
        dx_reg          <= dx_next;
        dy_reg          <= dy_next;
        err_reg         <= err_next;
        cell_marked_reg <= cell_marked_next;
    end

    assign ram_we    = cmd.clear_step || (mark_act && on_screen(mark_col, cur_row_reg));
    assign ram_waddr = cmd.clear_step ? clr_cnt_reg : cell_addr(mark_col, cur_row_reg);
    assign ram_wdata = !cmd.clear_step;
    assign ram_raddr = cell_addr(cur_col_reg, cur_row_reg);

    clp_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign sts.vertical   = (x_a == x_b);
    assign sts.line_done  = !err_up && !err_dn && (col_inc == end_col_reg);
    assign sts.vert_last  = (cur_row_reg == end_row_reg);
    assign sts.clear_last = (clr_cnt_reg == AW'(DEPTH - 1));

    assign cell_marked = cell_marked_reg;

endmodule

`default_nettype wire

// ===== rtl/clp_ctrl.sv =====
// Controller of the line plotter: request decode, sequencing FSM and the
// response valid flag. Depends on clp_pkg.
`default_nettype none

module clp_ctrl import clp_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [REQ_W-1:0] req_type,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output cmd_t                  cmd,
    input  wire sts_t             sts,
    output state_t                fsm_state
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (req_type)
                        REQ_DRAW:  state_next = sts.vertical ? ST_VERT : ST_START;
                        REQ_READ:  state_next = ST_READ;
                        REQ_CLEAR: state_next = ST_CLEAR;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_START:
            begin
                state_next = ST_LINE;
            end
            ST_LINE:
            begin
                if (sts.line_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_VERT:
            begin
                if (sts.vert_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready        = (state_reg == ST_IDLE);
        cmd.load        = (state_reg == ST_IDLE) && in_valid;
        cmd.clear_step  = (state_reg == ST_CLEAR);
        cmd.start_mark  = (state_reg == ST_START);
        cmd.line_step   = (state_reg == ST_LINE);
        cmd.vert_step   = (state_reg == ST_VERT);
        cmd.load_result = (state_reg == ST_RESULT) && slot_free;
        out_valid_next  = cmd.load_result || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign fsm_state = state_reg;

endmodule

`default_nettype wire

// ===== rtl/character_grid_line_plotter.sv =====
// Top level of the character grid line plotter: controller plus datapath.
// Depends on clp_pkg, clp_req_if, clp_rsp_if, clp_ctrl, clp_dp, clp_ram.
//
//  Channel | Dir | Beat carries                                   | Beats out
//  --------+-----+------------------------------------------------+-----------
//  req     | in  | req_type, x_a, y_a, x_b, y_b, read_col/row     | -
//  rsp     | out | cell_marked                                    | 1 per read
//
// Sequence: a line runs IDLE, START, LINE; a vertical line IDLE, VERT; a read
//   IDLE, READ, RESULT; an unused code stays in IDLE. The line stepper marks
//   one cell per cycle through the single RAM write port.
// Reset and clear: the bitmap is swept to zero one cell per cycle, covering
//   SCREEN_ROWS * 2**clog2(SCREEN_COLS) cells (2944 at 80 x 23);
//   req.ready stays low during the sweep.
// Stalls: the result sits in an output register; new requests are taken
//   while it waits, only a following read holds until the slot frees.
`default_nettype none

module character_grid_line_plotter import clp_pkg::*; #(
    parameter int SCREEN_COLS = DEF_SCREEN_COLS,
    parameter int SCREEN_ROWS = DEF_SCREEN_ROWS
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    clp_req_if.sink    req,
    clp_rsp_if.source  rsp
);

    cmd_t   cmd;
    sts_t   sts;
    state_t fsm_state;
    logic   req_ready;
    logic   rsp_valid;
    logic   rsp_cell_marked;

    // Sequencer: decodes request beats, walks the FSM, owns rsp.valid.
    clp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req_ready),
        .req_type  (req.req_type),
        .out_valid (rsp_valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts),
        .fsm_state (fsm_state)
    );

    // Datapath: endpoint scaling/ordering, error accumulator, bitmap RAM.
    clp_dp #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .req_type    (req.req_type),
        .x_a         (req.x_a),
        .y_a         (req.y_a),
        .x_b         (req.x_b),
        .y_b         (req.y_b),
        .read_col    (req.read_col),
        .read_row    (req.read_row),
        .cell_marked (rsp_cell_marked)
    );

    assign req.ready       = req_ready;
    assign rsp.valid       = rsp_valid;
    assign rsp.cell_marked = rsp_cell_marked;

    // No request is taken while the bitmap sweep runs.
    a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_state == ST_CLEAR) |-> !req.ready)
        else $error("request accepted during bitmap clear");

    // An accepted read goes straight to the RAM read cycle.
    a_read_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.req_type == REQ_READ) |=> (fsm_state == ST_READ))
        else $error("read request not sequenced to RAM read");

    // A new result never overwrites one still waiting on the response side.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_result |-> (!rsp.valid || rsp.ready))
        else $error("pending result overwritten");

    // The line stepper keeps running until the end column is marked.
    a_line_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_state == ST_LINE && !sts.line_done) |=> (fsm_state == ST_LINE))
        else $error("line stepper left before end column");

endmodule

`default_nettype wire
